// File: sv/can_bor_pkg.sv
// Shared types, codes and reset constants of the CAN bus-off recovery sequencer.
package can_bor_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int CH_W         = 2;
  localparam int CH_EXT_W     = 5;

  localparam logic [15:0] FAST_PERIOD_RST   = 16'd100;
  localparam logic [15:0] SLOW_PERIOD_RST   = 16'd200;
  localparam logic [7:0]  FAST_ATTEMPTS_RST = 8'd5;
  localparam logic [7:0]  SLOW_ATTEMPTS_RST = 8'd0;

  // Action codes of a request.
  localparam logic [2:0] ACT_PROCESS   = 3'd0;
  localparam logic [2:0] ACT_TICK      = 3'd1;
  localparam logic [2:0] ACT_BUSOFF    = 3'd2;
  localparam logic [2:0] ACT_RECOVERED = 3'd3;
  localparam logic [2:0] ACT_WR_FLAG   = 3'd4;

  // Recovery state codes as stored and reported.
  localparam logic [2:0] ST_NORMAL  = 3'd0;
  localparam logic [2:0] ST_PENDING = 3'd1;
  localparam logic [2:0] ST_SELECT  = 3'd2;
  localparam logic [2:0] ST_FAST    = 3'd3;
  localparam logic [2:0] ST_SLOW    = 3'd4;
  localparam logic [2:0] ST_RECOVER = 3'd5;
  localparam logic [2:0] ST_RWAIT   = 3'd6;

  // Bus status codes.
  localparam logic [1:0] BUS_NORMAL = 2'd0;
  localparam logic [1:0] BUS_OFF    = 2'd1;
  localparam logic [1:0] BUS_REINIT = 2'd2;

  // Recover flag values the sequencer itself uses.
  localparam logic [7:0] FLAG_CLEAR   = 8'd0;
  localparam logic [7:0] FLAG_RECOVER = 8'd1;
  localparam logic [7:0] FLAG_ACK     = 8'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FAST_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_SLOW_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_FAST_ATTEMPTS = 2'd2;
  localparam logic [1:0] CFG_SLOW_ATTEMPTS = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  channel;
    logic [7:0]  flag_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  channel_out;
    logic [2:0]  recovery_state;
    logic        stop_controller;
    logic        reinit_controller;
    logic [1:0]  busoff_status;
    logic [7:0]  recover_flag_out;
  } rsp_t;

  typedef struct packed {
    logic [15:0] fast_period_ms;
    logic [15:0] slow_period_ms;
    logic [7:0]  fast_attempts;
    logic [7:0]  slow_attempts;
  } cfg_t;

  // One channel's record as held in the state memory.
  typedef struct packed {
    logic [2:0]  state;
    logic [1:0]  busoff;
    logic [7:0]  flag;
    logic [15:0] fast_cnt;
    logic [15:0] slow_cnt;
    logic [7:0]  fast_left;
    logic [7:0]  slow_left;
  } rec_t;

endpackage

// File: sv/can_busoff_recovery_fsm.sv
// Top level of the per-channel CAN bus-off recovery sequencer.
//
// Usage: each request on req (req_valid/req_ready) names a channel and an
// action: process step, 1 ms tick, bus-off seen, bus recovered, or a write
// of the recover flag. Every request yields exactly one response on rsp
// (rsp_valid/rsp_ready) with the channel's state after the action and the
// stop/reinit pulses that the action raised.
// Order: a request's record is read at acceptance, then updated and written
// back as the response register is loaded, which a receiver stall can delay.
// Throughput: one request per cycle while the receiver does not stall, set by
// the single read and single write port of the state memory; a request to a
// channel whose record is written back as it is read takes the forwarded record.
// Reset (rst, synchronous): configuration returns to 100/200/5/0, every
// channel record reads as all zero (normal state) through per-entry valid
// bits; no clearing pass is needed. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
// Receiver stall: the response register holds; the update stage holds its
// request, and req_ready drops only when both are occupied.
module can_busoff_recovery_fsm #(
  parameter int CHANNELS = can_bor_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  can_bor_pkg::req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output can_bor_pkg::rsp_t  rsp,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [can_bor_pkg::CH_EXT_W-1:0] ChanLimit = can_bor_pkg::CH_EXT_W'(CHANNELS);

  can_bor_pkg::cfg_t cfg;

  // Update stage: the request whose record is being read out.
  logic              s1_valid;
  can_bor_pkg::req_t s1_req;

  logic                            accept;
  logic                            advance;
  logic [can_bor_pkg::CH_EXT_W-1:0] req_ch_ext;
  logic [can_bor_pkg::CH_EXT_W-1:0] s1_ch_ext;
  logic [IdxW-1:0]                 rd_addr;
  logic [IdxW-1:0]                 wr_addr;
  logic                            s1_in_range;

  can_bor_pkg::rec_t cur_rec;
  can_bor_pkg::rec_t nxt_rec;
  logic              stop;
  logic              reinit;
  can_bor_pkg::rsp_t rsp_next;

  // Advance the update stage when the response register is free or drains now.
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;
  assign accept    = req_valid && req_ready;

  assign req_ch_ext  = {3'b000, req.channel};
  assign s1_ch_ext   = {3'b000, s1_req.channel};
  assign rd_addr     = req_ch_ext[IdxW-1:0];
  assign wr_addr     = s1_ch_ext[IdxW-1:0];
  assign s1_in_range = s1_ch_ext < ChanLimit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_period_ms <= can_bor_pkg::FAST_PERIOD_RST;
      cfg.slow_period_ms <= can_bor_pkg::SLOW_PERIOD_RST;
      cfg.fast_attempts  <= can_bor_pkg::FAST_ATTEMPTS_RST;
      cfg.slow_attempts  <= can_bor_pkg::SLOW_ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        can_bor_pkg::CFG_FAST_PERIOD:   cfg.fast_period_ms <= cfg_data;
        can_bor_pkg::CFG_SLOW_PERIOD:   cfg.slow_period_ms <= cfg_data;
        can_bor_pkg::CFG_FAST_ATTEMPTS: cfg.fast_attempts  <= cfg_data[7:0];
        can_bor_pkg::CFG_SLOW_ATTEMPTS: cfg.slow_attempts  <= cfg_data[7:0];
        default: cfg <= cfg;
      endcase
    end
  end

  // Channel records: read on accept, write back when the update stage advances.
  can_bor_store #(
    .Channels(CHANNELS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (advance && s1_in_range),
    .wr_addr (wr_addr),
    .wr_data (nxt_rec),
    .rd_rec  (cur_rec)
  );

  can_bor_update u_update (
    .req    (s1_req),
    .cfg    (cfg),
    .cur    (cur_rec),
    .nxt    (nxt_rec),
    .stop   (stop),
    .reinit (reinit)
  );

  can_bor_pack u_pack (
    .req      (s1_req),
    .in_range (s1_in_range),
    .nxt      (nxt_rec),
    .stop     (stop),
    .reinit   (reinit),
    .rsp      (rsp_next)
  );

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // A stop pulse always comes with the move into the pending state.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.stop_controller |->
      rsp.recovery_state == can_bor_pkg::ST_PENDING && !rsp.reinit_controller)
    else $error("stop pulse without move to pending");

  // A reinit pulse always lands in recover with the bus marked reinit done.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reinit_controller |->
      rsp.recovery_state == can_bor_pkg::ST_RECOVER &&
      rsp.busoff_status == can_bor_pkg::BUS_REINIT)
    else $error("reinit pulse with wrong state or bus status");

  // A response for a channel the block lacks carries nothing but the channel.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ({3'b000, rsp.channel_out} >= ChanLimit) |->
      rsp.recovery_state == can_bor_pkg::ST_NORMAL &&
      !rsp.stop_controller && !rsp.reinit_controller &&
      rsp.busoff_status == can_bor_pkg::BUS_NORMAL &&
      rsp.recover_flag_out == can_bor_pkg::FLAG_CLEAR)
    else $error("out-of-range channel response not cleared");

  // A request held in the update stage moves on as soon as the response register frees.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !rsp_valid |=> rsp_valid)
    else $error("update stage failed to advance into free response register");

endmodule

// File: sv/can_bor_store.sv
// Per-channel state memory with valid bits and write-to-read forwarding.
module can_bor_store #(
  parameter int Channels = can_bor_pkg::CHANNELS_DEF,
  localparam int IdxW = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IdxW-1:0]     rd_addr,
  input  logic                wr_en,
  input  logic [IdxW-1:0]     wr_addr,
  input  can_bor_pkg::rec_t   wr_data,
  output can_bor_pkg::rec_t   rd_rec
);

  can_bor_pkg::rec_t mem [Channels];
  logic [Channels-1:0] entry_valid;

  can_bor_pkg::rec_t rd_data;
  logic              rd_valid;
  logic [IdxW-1:0]   rd_addr_q;

  can_bor_pkg::rec_t fwd_data;
  logic              fwd_valid;
  logic [IdxW-1:0]   fwd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
        fwd_valid            <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  // Last write wins over a read that raced it; never-written entries read as reset.
  always_comb begin
    if (fwd_valid && (fwd_addr == rd_addr_q)) begin
      rd_rec = fwd_data;
    end else if (rd_valid) begin
      rd_rec = rd_data;
    end else begin
      rd_rec = '0;
    end
  end

endmodule

// File: sv/can_bor_update.sv
// Next-record logic: applies one request's action to a channel record.
module can_bor_update (
  input  can_bor_pkg::req_t  req,
  input  can_bor_pkg::cfg_t  cfg,
  input  can_bor_pkg::rec_t  cur,
  output can_bor_pkg::rec_t  nxt,
  output logic               stop,
  output logic               reinit
);

  can_bor_pkg::rec_t wait_rec;

  // Arm the wait counter of the mode still in use.
  always_comb begin
    wait_rec = cur;
    if (cur.fast_left != 8'd0) begin
      wait_rec.fast_cnt = cfg.fast_period_ms;
    end else begin
      wait_rec.slow_cnt = cfg.slow_period_ms;
    end
  end

  always_comb begin
    nxt    = cur;
    stop   = 1'b0;
    reinit = 1'b0;
    unique case (req.action)
      can_bor_pkg::ACT_PROCESS: begin
        unique case (cur.state)
          can_bor_pkg::ST_NORMAL: begin
            if (cur.busoff == can_bor_pkg::BUS_OFF) begin
              stop          = 1'b1;
              nxt.state     = can_bor_pkg::ST_PENDING;
              nxt.fast_left = cfg.fast_attempts;
              nxt.slow_left = cfg.slow_attempts;
            end
          end
          can_bor_pkg::ST_RECOVER: begin
            nxt.flag  = can_bor_pkg::FLAG_RECOVER;
            nxt.state = can_bor_pkg::ST_RWAIT;
          end
          can_bor_pkg::ST_RWAIT: begin
            if (cur.busoff == can_bor_pkg::BUS_OFF) begin
              nxt       = wait_rec;
              stop      = 1'b1;
              nxt.state = can_bor_pkg::ST_PENDING;
            end else if (cur.busoff == can_bor_pkg::BUS_NORMAL) begin
              nxt.state = can_bor_pkg::ST_NORMAL;
            end
            if (cur.flag == can_bor_pkg::FLAG_ACK) begin
              nxt.flag = can_bor_pkg::FLAG_CLEAR;
            end
          end
          can_bor_pkg::ST_PENDING: begin
            nxt       = wait_rec;
            nxt.state = can_bor_pkg::ST_SELECT;
          end
          can_bor_pkg::ST_SELECT: begin
            nxt.state = (cur.fast_left != 8'd0) ? can_bor_pkg::ST_FAST : can_bor_pkg::ST_SLOW;
          end
          can_bor_pkg::ST_FAST: begin
            if (cur.fast_cnt == 16'd0) begin
              reinit     = 1'b1;
              nxt.busoff = can_bor_pkg::BUS_REINIT;
              nxt.state  = can_bor_pkg::ST_RECOVER;
              if (cur.fast_left != 8'd0) begin
                nxt.fast_left = cur.fast_left - 8'd1;
              end
            end
          end
          can_bor_pkg::ST_SLOW: begin
            if (cur.slow_cnt == 16'd0) begin
              reinit     = 1'b1;
              nxt.busoff = can_bor_pkg::BUS_REINIT;
              nxt.state  = can_bor_pkg::ST_RECOVER;
              if (cur.slow_left != 8'd0) begin
                nxt.slow_left = cur.slow_left - 8'd1;
              end
            end
          end
          default: begin
            nxt.state = can_bor_pkg::ST_NORMAL;
          end
        endcase
      end
      can_bor_pkg::ACT_TICK: begin
        if (cur.fast_cnt != 16'd0) begin
          nxt.fast_cnt = cur.fast_cnt - 16'd1;
        end
        if (cur.slow_cnt != 16'd0) begin
          nxt.slow_cnt = cur.slow_cnt - 16'd1;
        end
      end
      can_bor_pkg::ACT_BUSOFF: begin
        nxt.busoff = can_bor_pkg::BUS_OFF;
      end
      can_bor_pkg::ACT_RECOVERED: begin
        nxt.busoff = can_bor_pkg::BUS_NORMAL;
      end
      can_bor_pkg::ACT_WR_FLAG: begin
        nxt.flag = req.flag_value;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: sv/can_bor_recovery_fsm_top_note.sv
// Response packing: forms one response from a channel's updated record.
module can_bor_pack (
  input  can_bor_pkg::req_t  req,
  input  logic               in_range,
  input  can_bor_pkg::rec_t  nxt,
  input  logic               stop,
  input  logic               reinit,
  output can_bor_pkg::rsp_t  rsp
);

  always_comb begin
    rsp             = '0;
    rsp.channel_out = req.channel;
    // Drop everything but the channel for a channel the block does not have.
    if (in_range) begin
      rsp.recovery_state    = nxt.state;
      rsp.stop_controller   = stop;
      rsp.reinit_controller = reinit;
      rsp.busoff_status     = nxt.busoff;
      rsp.recover_flag_out  = nxt.flag;
    end
  end

endmodule

// File: test/tb_can_busoff_recovery_fsm.sv
`timescale 1ns / 100ps
// Self-checking testbench of the per-channel CAN bus-off recovery sequencer.
module tb_can_busoff_recovery_fsm;

  localparam int NCH         = can_bor_pkg::CHANNELS_DEF;
  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 20;     // settle time once nothing is pending
  localparam int NPH         = 7;

  // Settings visited by the random part: reset values, both extremes and a
  // handful of short periods so that recovery attempts actually fire.
  int ph_fast[NPH]  = '{100, 0, 3, 65535, 2, 1, 0};
  int ph_slow[NPH]  = '{200, 0, 5, 65535, 1, 4, 3};
  int ph_fatt[NPH]  = '{5, 0, 2, 255, 3, 255, 1};
  int ph_satt[NPH]  = '{0, 0, 1, 255, 0, 7, 0};
  int ph_items[NPH] = '{60, 85, 85, 40, 85, 85, 85};

  logic  clk = 1'b0;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  can_bor_pkg::req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  can_bor_pkg::rsp_t  rsp;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bit steady;          // set: neither side inserts gaps
  int reqs_sent;
  int episodes;

  // Tracks every channel's recovery state and holds the responses still owed.
  class recovery_tracker;
    logic [15:0] fast_ticks;
    logic [15:0] slow_ticks;
    logic [7:0]  fast_att;
    logic [7:0]  slow_att;
    logic [2:0]  state_q[NCH];
    logic [1:0]  bus_q[NCH];
    logic [7:0]  flag_q[NCH];
    logic [15:0] fast_cnt[NCH];
    logic [15:0] slow_cnt[NCH];
    logic [7:0]  fast_left[NCH];
    logic [7:0]  slow_left[NCH];
    can_bor_pkg::rsp_t owed_rsp[$];
    int          errors;
    int          stops;
    int          reinits;

    function new();
      fast_ticks = can_bor_pkg::FAST_PERIOD_RST;
      slow_ticks = can_bor_pkg::SLOW_PERIOD_RST;
      fast_att   = can_bor_pkg::FAST_ATTEMPTS_RST;
      slow_att   = can_bor_pkg::SLOW_ATTEMPTS_RST;
      for (int i = 0; i < NCH; i++) begin
        state_q[i]   = can_bor_pkg::ST_NORMAL;
        bus_q[i]     = can_bor_pkg::BUS_NORMAL;
        flag_q[i]    = can_bor_pkg::FLAG_CLEAR;
        fast_cnt[i]  = '0;
        slow_cnt[i]  = '0;
        fast_left[i] = '0;
        slow_left[i] = '0;
      end
      errors  = 0;
      stops   = 0;
      reinits = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        can_bor_pkg::CFG_FAST_PERIOD:   fast_ticks = val;
        can_bor_pkg::CFG_SLOW_PERIOD:   slow_ticks = val;
        can_bor_pkg::CFG_FAST_ATTEMPTS: fast_att   = val[7:0];
        can_bor_pkg::CFG_SLOW_ATTEMPTS: slow_att   = val[7:0];
        default: ;
      endcase
    endfunction

    // Arm the counter of the mode that the next attempt will use.
    function void arm_wait(int c);
      if (fast_left[c] > 0) fast_cnt[c] = fast_ticks;
      else slow_cnt[c] = slow_ticks;
    endfunction

    function void note_request(can_bor_pkg::req_t r);
      can_bor_pkg::rsp_t o;
      int          c;
      logic [2:0]  st;
      logic        stop;
      logic        reinit;
      o      = '0;
      c      = int'(r.channel);
      stop   = 1'b0;
      reinit = 1'b0;
      o.channel_out = r.channel;
      if (c < NCH) begin
        case (r.action)
          can_bor_pkg::ACT_PROCESS: begin
            st = state_q[c];
            case (st)
              can_bor_pkg::ST_NORMAL: begin
                if (bus_q[c] == can_bor_pkg::BUS_OFF) begin
                  stop         = 1'b1;
                  st           = can_bor_pkg::ST_PENDING;
                  fast_left[c] = fast_att;
                  slow_left[c] = slow_att;
                end
              end
              can_bor_pkg::ST_RECOVER: begin
                flag_q[c] = can_bor_pkg::FLAG_RECOVER;
                st        = can_bor_pkg::ST_RWAIT;
              end
              can_bor_pkg::ST_RWAIT: begin
                if (flag_q[c] == can_bor_pkg::FLAG_ACK) flag_q[c] = can_bor_pkg::FLAG_CLEAR;
                if (bus_q[c] == can_bor_pkg::BUS_NORMAL) begin
                  st = can_bor_pkg::ST_NORMAL;
                end else if (bus_q[c] == can_bor_pkg::BUS_OFF) begin
                  stop = 1'b1;
                  st   = can_bor_pkg::ST_PENDING;
                  arm_wait(c);
                end
              end
              can_bor_pkg::ST_PENDING: begin
                arm_wait(c);
                st = can_bor_pkg::ST_SELECT;
              end
              can_bor_pkg::ST_SELECT: begin
                st = (fast_left[c] > 0) ? can_bor_pkg::ST_FAST : can_bor_pkg::ST_SLOW;
              end
              can_bor_pkg::ST_FAST: begin
                if (fast_cnt[c] == 0) begin
                  reinit = 1'b1;
                  bus_q[c] = can_bor_pkg::BUS_REINIT;
                  if (fast_left[c] > 0) fast_left[c] = fast_left[c] - 8'd1;
                  st = can_bor_pkg::ST_RECOVER;
                end
              end
              can_bor_pkg::ST_SLOW: begin
                if (slow_cnt[c] == 0) begin
                  reinit = 1'b1;
                  bus_q[c] = can_bor_pkg::BUS_REINIT;
                  if (slow_left[c] > 0) slow_left[c] = slow_left[c] - 8'd1;
                  st = can_bor_pkg::ST_RECOVER;
                end
              end
              default: st = can_bor_pkg::ST_NORMAL;
            endcase
            state_q[c] = st;
          end
          can_bor_pkg::ACT_TICK: begin
            if (fast_cnt[c] > 0) fast_cnt[c] = fast_cnt[c] - 16'd1;
            if (slow_cnt[c] > 0) slow_cnt[c] = slow_cnt[c] - 16'd1;
          end
          can_bor_pkg::ACT_BUSOFF:    bus_q[c]  = can_bor_pkg::BUS_OFF;
          can_bor_pkg::ACT_RECOVERED: bus_q[c]  = can_bor_pkg::BUS_NORMAL;
          can_bor_pkg::ACT_WR_FLAG:   flag_q[c] = r.flag_value;
          default: ;
        endcase
        o.recovery_state    = state_q[c];
        o.stop_controller   = stop;
        o.reinit_controller = reinit;
        o.busoff_status     = bus_q[c];
        o.recover_flag_out  = flag_q[c];
      end
      if (stop) stops++;
      if (reinit) reinits++;
      owed_rsp.push_back(o);
    endfunction

    task report(string what, int exp_v, int got_v);
      if (errors < 40) $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
      errors++;
    endtask

    task check_response(can_bor_pkg::rsp_t got);
      can_bor_pkg::rsp_t exp_r;
      if (owed_rsp.size() == 0) begin
        report("response with no request pending", 0, int'(got));
      end else begin
        exp_r = owed_rsp.pop_front();
        if (got.channel_out !== exp_r.channel_out)
          report("channel_out", int'(exp_r.channel_out), int'(got.channel_out));
        if (got.recovery_state !== exp_r.recovery_state)
          report("recovery_state", int'(exp_r.recovery_state), int'(got.recovery_state));
        if (got.stop_controller !== exp_r.stop_controller)
          report("stop_controller", int'(exp_r.stop_controller), int'(got.stop_controller));
        if (got.reinit_controller !== exp_r.reinit_controller)
          report("reinit_controller", int'(exp_r.reinit_controller),
                 int'(got.reinit_controller));
        if (got.busoff_status !== exp_r.busoff_status)
          report("busoff_status", int'(exp_r.busoff_status), int'(got.busoff_status));
        if (got.recover_flag_out !== exp_r.recover_flag_out)
          report("recover_flag_out", int'(exp_r.recover_flag_out),
                 int'(got.recover_flag_out));
      end
    endtask

    function int outstanding();
      return owed_rsp.size();
    endfunction
  endclass

  recovery_tracker trk = new();

  can_busoff_recovery_fsm #(
    .CHANNELS(NCH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one request: idle for a random gap, then hold valid and payload
  // until the block takes the request.
  task automatic send_item(input logic [2:0] act, input logic [1:0] ch, input logic [7:0] val);
    can_bor_pkg::req_t r;
    int   gap;
    r.action     = act;
    r.channel    = ch;
    r.flag_value = val;
    gap = steady ? 0 : ($urandom_range(0, 1) ? 0 : pick_gap());
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    reqs_sent++;
  endtask

  // Drop valid and hold off until every owed response has come back.
  task automatic drain_all();
    req_valid <= 1'b0;
    do @(posedge clk); while (trk.outstanding() != 0);
  endtask

  // Write one register at the next edge; the caller lowers the enable.
  task automatic cfg_put(input logic [1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    trk.write_reg(idx, 16'(val));
    @(posedge clk);
  endtask

  task automatic write_settings(input int fp, input int sp, input int fa, input int sa);
    cfg_put(can_bor_pkg::CFG_FAST_PERIOD, fp);
    cfg_put(can_bor_pkg::CFG_SLOW_PERIOD, sp);
    cfg_put(can_bor_pkg::CFG_FAST_ATTEMPTS, fa);
    cfg_put(can_bor_pkg::CFG_SLOW_ATTEMPTS, sa);
    cfg_we <= 1'b0;
  endtask

  // Note accepted requests and check accepted responses; values are the
  // ones that stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) trk.note_request(req);
      if (rsp_valid && rsp_ready) trk.check_response(rsp);
    end
  end

  // Receiver: random stalls, none while the steady flag is set.
  initial begin : rsp_side
    int hold;
    hold = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int          goal;
    int          cap;
    int          n;
    logic [1:0]  c;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= can_bor_pkg::CFG_FAST_PERIOD;
    cfg_data  <= '0;
    steady    = 1'b0;
    reqs_sent = 0;
    episodes  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed walk: short periods, one fast attempt, then slow mode.
    write_settings(1, 2, 1, 255);
    send_item(can_bor_pkg::ACT_WR_FLAG, 2'd3, 8'hFF);       // flag extremes
    send_item(can_bor_pkg::ACT_WR_FLAG, 2'd3, 8'h00);
    send_item(3'd7, 2'd3, 8'hAA);              // unknown actions leave state alone
    send_item(3'd5, 2'd1, 8'h55);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // normal, bus fine: hold
    send_item(can_bor_pkg::ACT_TICK, 2'd0, 8'h00);          // counters already at zero
    send_item(can_bor_pkg::ACT_BUSOFF, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // stop pulse, pending
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // arm fast wait, select
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // fast wait
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // count not yet zero
    send_item(can_bor_pkg::ACT_TICK, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // reinit pulse, recover
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // flag set, recover wait
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // reinit done: hold
    send_item(can_bor_pkg::ACT_WR_FLAG, 2'd0, can_bor_pkg::FLAG_ACK);
    send_item(can_bor_pkg::ACT_BUSOFF, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // clear ack, stop, arm slow
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // no fast attempts left
    send_item(can_bor_pkg::ACT_TICK, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_TICK, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // reinit from slow wait
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_RECOVERED, 2'd0, 8'h00);
    send_item(can_bor_pkg::ACT_PROCESS, 2'd0, 8'h00);       // back to normal

    // Random part: bus-off episodes with random content, mixed with noise.
    for (int p = 0; p < NPH; p++) begin
      drain_all();
      write_settings(ph_fast[p], ph_slow[p], ph_fatt[p], ph_satt[p]);
      steady = (p % 3 == 1);
      goal   = reqs_sent + ph_items[p];
      cap    = (ph_slow[p] > ph_fast[p]) ? ph_slow[p] : ph_fast[p];
      if (cap > 8) cap = 8;
      while (reqs_sent < goal) begin
        c = 2'($urandom_range(0, NCH - 1));
        episodes++;
        send_item(can_bor_pkg::ACT_BUSOFF, c, 8'($urandom));
        repeat (3) send_item(can_bor_pkg::ACT_PROCESS, c, 8'($urandom));
        n = $urandom_range(2, 2 * cap + 2);
        repeat (n) begin
          if ($urandom_range(0, 99) < 15)
            send_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, NCH - 1)),
                      8'($urandom));
          send_item($urandom_range(0, 1) ? can_bor_pkg::ACT_TICK : can_bor_pkg::ACT_PROCESS,
                    c, 8'($urandom));
        end
        repeat (2) send_item(can_bor_pkg::ACT_PROCESS, c, 8'($urandom));
        if ($urandom_range(0, 1))
          send_item(can_bor_pkg::ACT_WR_FLAG, c,
                    $urandom_range(0, 1) ? can_bor_pkg::FLAG_ACK : 8'($urandom));
        case ($urandom_range(0, 2))
          0: send_item(can_bor_pkg::ACT_RECOVERED, c, 8'($urandom));
          1: send_item(can_bor_pkg::ACT_BUSOFF, c, 8'($urandom));
          default: ;
        endcase
        repeat ($urandom_range(1, 3)) send_item(can_bor_pkg::ACT_PROCESS, c, 8'($urandom));
        // Now and then hold the sender until the pipeline is empty.
        if ($urandom_range(0, 9) == 0) drain_all();
        if ($urandom_range(0, 4) == 0) steady = !steady;
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trk.outstanding() != 0) trk.report("responses never delivered", 0, trk.outstanding());

    $display("Covered %0d requests under %0d register settings in %0d bus-off episodes,",
             reqs_sent, NPH + 1, episodes);
    $display("with %0d stop and %0d reinit pulses; %0d mismatches.",
             trk.stops, trk.reinits, trk.errors);
    if (trk.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/can_bor_pkg.sv
sv/can_bor_store.sv
sv/can_bor_update.sv
sv/can_bor_recovery_fsm_top_note.sv
sv/can_busoff_recovery_fsm.sv
test/tb_can_busoff_recovery_fsm.sv
